// ===== rtl/btmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 4096;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = ADDR_W + 1;
  localparam int LVL_W      = $clog2(KEY_BITS);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_EMPTY     = 2'd2
  } status_e;

  // two child links, index 0 and 1 by key bit, zero means no child
  typedef logic [1:0][ADDR_W-1:0] node_t;

  typedef struct packed {
    logic                operation;
    logic [KEY_BITS-1:0] key_value;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_BITS-1:0] partner_key;
    logic [KEY_BITS-1:0] xor_value;
    logic [KEY_BITS-1:0] best_overall;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/binary_trie_max_xor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary trie for maximum-XOR pairing of 31-bit keys, one item at a time.
// An insert walks the trie from the top key bit down, one level per cycle
// through the node memory (4096 entries of two 12-bit child links, read data
// registered), and writes one missing node per cycle once the path runs out;
// if the free pool cannot hold the whole missing tail nothing is written and
// status reports pool full. A query takes the opposite branch wherever it
// exists and returns the best partner key, the XOR and the running maximum
// of that XOR; a query before any insert reports an empty trie. The key
// rotates through a shift register and the partner is built one bit per
// cycle. A query or a duplicate insert goes from its input transfer to its
// result through a read of the root, the walk down every key level and the
// hand-over of the result to the output register. An insert that adds
// nodes spends the levels below its first missing link on node writes
// instead of reads, plus one write for the parent link. A query on an empty
// trie goes straight to the hand-over, and a full pool ends the insert at
// its first missing link. The hand-over waits while the output register
// holds a stalled result. A new item is taken only while the walk is idle,
// that is once the previous item has been handed over; a finished result
// may sit in the output register while the next item is already being
// walked.
module binary_trie_max_xor_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire btmx_pkg::in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output btmx_pkg::out_t        out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_WALK   = 5'b00100,
    S_ALLOC  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [btmx_pkg::FREE_W-1:0] next_free_q, next_free_d;
  logic                        root_has_child_q, root_has_child_d;
  logic [btmx_pkg::KEY_BITS-1:0] best_q, best_d;
  logic                        out_valid_q, out_valid_d;

  // per-item working registers
  logic [btmx_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [btmx_pkg::KEY_BITS-1:0] partner_q, partner_d;
  logic [btmx_pkg::ADDR_W-1:0]   node_q, node_d;
  logic [btmx_pkg::LVL_W-1:0]    level_q, level_d;
  logic                          op_q, op_d;
  logic [1:0]                    status_q, status_d;
  logic                          dead_q, dead_d;
  btmx_pkg::out_t                out_q, out_d;

  // node memory
  btmx_pkg::node_t             mem [btmx_pkg::NODE_COUNT];
  btmx_pkg::node_t             rdata_q;
  logic                        mem_we;
  logic [btmx_pkg::ADDR_W-1:0] mem_waddr;
  logic [btmx_pkg::ADDR_W-1:0] mem_raddr;
  btmx_pkg::node_t             mem_wdata;

  // walk helpers
  btmx_pkg::node_t             links;
  logic                        kbit;
  logic [btmx_pkg::ADDR_W-1:0] same_link;
  logic [btmx_pkg::ADDR_W-1:0] opp_link;
  logic [btmx_pkg::FREE_W:0]   fill_sum;
  logic                        pool_full;
  logic                        accept;
  logic                        out_free;
  logic [btmx_pkg::KEY_BITS-1:0] xor_res;
  logic                        query_ok;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // root reads as childless until the first insert writes it
  assign links = ((node_q == '0) && !root_has_child_q) ? '0 : rdata_q;
  assign kbit      = key_q[btmx_pkg::KEY_BITS-1];
  assign same_link = links[kbit];
  assign opp_link  = links[~kbit];

  // the missing tail below and including this level must fit in the pool
  assign fill_sum  = (btmx_pkg::FREE_W+1)'(next_free_q)
                   + (btmx_pkg::FREE_W+1)'(level_q)
                   + (btmx_pkg::FREE_W+1)'(1);
  assign pool_full = fill_sum > (btmx_pkg::FREE_W+1)'(btmx_pkg::NODE_COUNT);

  // key has rotated back to its original value by the end of a query walk
  assign query_ok = (op_q == btmx_pkg::OP_QUERY) && (status_q == btmx_pkg::ST_OK);
  assign xor_res  = query_ok ? (key_q ^ partner_q) : '0;

  always_comb begin
    state_d          = state_q;
    next_free_d      = next_free_q;
    root_has_child_d = root_has_child_q;
    best_d           = best_q;
    out_valid_d      = out_valid_q;
    key_d            = key_q;
    partner_d        = partner_q;
    node_d           = node_q;
    level_d          = level_q;
    op_d             = op_q;
    status_d         = status_q;
    dead_d           = dead_q;
    out_d            = out_q;
    mem_we           = 1'b0;
    mem_waddr        = node_q;
    mem_wdata        = links;
    mem_raddr        = node_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d     = in_data_i.key_value;
          op_d      = in_data_i.operation;
          partner_d = '0;
          node_d    = '0;
          dead_d    = 1'b0;
          level_d   = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          status_d  = btmx_pkg::ST_OK;
          if ((in_data_i.operation == btmx_pkg::OP_QUERY) && !root_has_child_q) begin
            status_d = btmx_pkg::ST_EMPTY;
            state_d  = S_FINISH;
          end else begin
            state_d = S_START;
          end
        end
      end

      S_START: begin
        // root read in flight
        mem_raddr = '0;
        state_d   = S_WALK;
      end

      S_WALK: begin
        if (op_q == btmx_pkg::OP_QUERY) begin
          // prefer the opposite branch, fall back to the same one
          if (dead_q) begin
            partner_d = {partner_q[btmx_pkg::KEY_BITS-2:0], 1'b0};
            node_d    = '0;
          end else if (opp_link != '0) begin
            partner_d = {partner_q[btmx_pkg::KEY_BITS-2:0], ~kbit};
            node_d    = opp_link;
          end else if (same_link != '0) begin
            partner_d = {partner_q[btmx_pkg::KEY_BITS-2:0], kbit};
            node_d    = same_link;
          end else begin
            partner_d = {partner_q[btmx_pkg::KEY_BITS-2:0], 1'b0};
            node_d    = '0;
            dead_d    = 1'b1;
          end
          mem_raddr = node_d;
          key_d     = {key_q[btmx_pkg::KEY_BITS-2:0], kbit};
          if (level_q == '0) begin
            state_d = S_FINISH;
          end else begin
            level_d = level_q - 1'b1;
          end
        end else begin
          if (same_link != '0) begin
            // path already present at this level
            node_d    = same_link;
            mem_raddr = same_link;
            key_d     = {key_q[btmx_pkg::KEY_BITS-2:0], kbit};
            if (level_q == '0) begin
              state_d = S_FINISH;
            end else begin
              level_d = level_q - 1'b1;
            end
          end else if (pool_full) begin
            status_d = btmx_pkg::ST_POOL_FULL;
            state_d  = S_FINISH;
          end else begin
            // hook the first new node into its parent
            mem_we           = 1'b1;
            mem_waddr        = node_q;
            mem_wdata        = links;
            mem_wdata[kbit]  = next_free_q[btmx_pkg::ADDR_W-1:0];
            root_has_child_d = 1'b1;
            key_d            = {key_q[btmx_pkg::KEY_BITS-2:0], kbit};
            state_d          = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        // each new node links to the next one, the leaf stays empty
        mem_we    = 1'b1;
        mem_waddr = next_free_q[btmx_pkg::ADDR_W-1:0];
        mem_wdata = '0;
        if (level_q != '0) begin
          mem_wdata[kbit] = btmx_pkg::ADDR_W'(next_free_q + 1'b1);
        end
        next_free_d = next_free_q + 1'b1;
        if (level_q == '0) begin
          state_d = S_FINISH;
        end else begin
          level_d = level_q - 1'b1;
          key_d   = {key_q[btmx_pkg::KEY_BITS-2:0], kbit};
        end
      end

      S_FINISH: begin
        if (out_free) begin
          if (query_ok && (xor_res > best_q)) begin
            best_d = xor_res;
          end
          out_d.status       = status_q;
          out_d.partner_key  = query_ok ? partner_q : '0;
          out_d.xor_value    = xor_res;
          out_d.best_overall = (query_ok && (xor_res > best_q)) ? xor_res : best_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // node memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      next_free_q      <= btmx_pkg::FREE_W'(1);
      root_has_child_q <= 1'b0;
      best_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      next_free_q      <= next_free_d;
      root_has_child_q <= root_has_child_d;
      best_q           <= best_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    partner_q <= partner_d;
    node_q    <= node_d;
    level_q   <= level_d;
    op_q      <= op_d;
    status_q  <= status_d;
    dead_q    <= dead_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire
